### hdl/bpp_pkg.sv
package bpp_pkg;

   // stream markers
   localparam logic [31:0] SYNC_NATIVE  = 32'hAA995566;
   localparam logic [31:0] SYNC_SWAPPED = 32'h665599AA;
   localparam logic [31:0] NOOP_WORD    = 32'h20000000;
   localparam logic [31:0] TYPE_MASK    = 32'hF0000000;
   localparam logic [31:0] TYPE1_WRITE  = 32'h30000000;

   // header layout
   localparam int COUNT_W      = 11;
   localparam int ADDR_W       = 5;
   localparam int HDR_ADDR_LSB = 13;

   // registers with decoded payloads
   localparam logic [ADDR_W-1:0] REG_COMMAND = 5'b00100;
   localparam logic [ADDR_W-1:0] REG_CONTROL = 5'b01001;
   localparam logic [31:0]       CMD_MAX     = 32'd19;

   typedef enum logic [2:0] {
      KIND_HUNT    = 3'd0,
      KIND_SYNC    = 3'd1,
      KIND_NOOP    = 3'd2,
      KIND_HEADER  = 3'd3,
      KIND_PAYLOAD = 3'd4,
      KIND_UNKNOWN = 3'd5
   } word_kind_type;

   typedef struct packed {
      word_kind_type     word_kind;
      logic [ADDR_W-1:0] reg_addr;
      logic [31:0]       word_value;
      logic              payload_last;
      logic              byte_swapped;
      logic              command_valid;
      logic [2:0]        gwe_cycle;
      logic [2:0]        gts_cycle;
      logic [2:0]        lock_wait;
      logic [2:0]        match_wait;
      logic [2:0]        done_cycle;
   } result_type;

   // byte reversal for opposite-endian streams
   function automatic logic [31:0] reorder(input logic [31:0] v, input logic sw);
      logic [31:0] r;
      r = sw ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
      return r;
   endfunction

endpackage

### hdl/bpp_if.sv
interface bpp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] raw_word;

   modport source (output valid, output raw_word, input ready);
   modport sink   (input valid, input raw_word, output ready);
endinterface

interface bpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  word_kind;
   logic [4:0]  reg_addr;
   logic [31:0] word_value;
   logic        payload_last;
   logic        byte_swapped;
   logic        command_valid;
   logic [2:0]  gwe_cycle;
   logic [2:0]  gts_cycle;
   logic [2:0]  lock_wait;
   logic [2:0]  match_wait;
   logic [2:0]  done_cycle;

   modport source (output valid, output word_kind, output reg_addr, output word_value,
                   output payload_last, output byte_swapped, output command_valid,
                   output gwe_cycle, output gts_cycle, output lock_wait,
                   output match_wait, output done_cycle, input ready);
   modport sink   (input valid, input word_kind, input reg_addr, input word_value,
                   input payload_last, input byte_swapped, input command_valid,
                   input gwe_cycle, input gts_cycle, input lock_wait,
                   input match_wait, input done_cycle, output ready);
endinterface

### hdl/bpp_decode.sv
module bpp_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [31:0]          raw_word,
   output bpp_pkg::result_type  result
);
   import bpp_pkg::*;

   logic                synced_ff, synced_in;
   logic                swap_ff, swap_in;
   logic [COUNT_W-1:0]  left_ff, left_in;
   logic [ADDR_W-1:0]   reg_ff, reg_in;
   logic [31:0]         value;

   // sync hunt, then packet decode
   always_comb begin
      result    = '0;
      result.word_kind = KIND_HUNT;
      synced_in = synced_ff;
      swap_in   = swap_ff;
      left_in   = left_ff;
      reg_in    = reg_ff;
      value     = reorder(raw_word, swap_ff);
      if (!synced_ff) begin
         if (raw_word == SYNC_NATIVE) begin
            synced_in = 1'b1;
            swap_in   = 1'b0;
            result.word_kind = KIND_SYNC;
         end else if (raw_word == SYNC_SWAPPED) begin
            synced_in = 1'b1;
            swap_in   = 1'b1;
            result.word_kind = KIND_SYNC;
         end
         value = reorder(raw_word, swap_in);
      end else if (left_ff != '0) begin
         // payload of the pending header, whatever it looks like
         result.word_kind    = KIND_PAYLOAD;
         result.reg_addr     = reg_ff;
         result.payload_last = (left_ff == COUNT_W'(1));
         left_in             = left_ff - COUNT_W'(1);
         result.command_valid = (reg_ff == REG_COMMAND) && (value <= CMD_MAX);
         if (reg_ff == REG_CONTROL) begin
            result.gwe_cycle  = value[2:0];
            result.gts_cycle  = value[5:3];
            result.lock_wait  = value[8:6];
            result.match_wait = value[11:9];
            result.done_cycle = value[14:12];
         end
      end else if (value == NOOP_WORD) begin
         result.word_kind = KIND_NOOP;
      end else if ((value & TYPE_MASK) == TYPE1_WRITE) begin
         result.word_kind = KIND_HEADER;
         left_in          = value[COUNT_W-1:0];
         reg_in           = value[HDR_ADDR_LSB +: ADDR_W];
         result.reg_addr  = reg_in;
      end else begin
         result.word_kind = KIND_UNKNOWN;
      end
      result.word_value   = value;
      result.byte_swapped = swap_in;
   end

   // parser state, advanced once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff <= 1'b0;
         swap_ff   <= 1'b0;
         left_ff   <= '0;
         reg_ff    <= '0;
      end else if (step) begin
         synced_ff <= synced_in;
         swap_ff   <= swap_in;
         left_ff   <= left_in;
         reg_ff    <= reg_in;
      end
   end

endmodule

### hdl/bitstream_packet_parser.sv
// A request word is held in the input register while it is decoded, and its result is
// registered in the output register, from which it is presented on rsp.
// Throughput: one word per cycle while rsp does not stall; there is a single input and a single output register.
// Backpressure on rsp stalls the output register, then the input register, then req_ready.
// Reset (synchronous, active high) clears sync, byte order, payload count, register
// address and both valid flags.
module bitstream_packet_parser (
   input logic        clock,
   input logic        reset,
   bpp_req_if.sink    req_port,
   bpp_rsp_if.source  rsp_port
);
   import bpp_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [31:0] in_word_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   result_type  dec_result;
   logic        advance;
   logic        step;
   logic        req_take;

   // pipeline moves when the output register is free or being drained
   assign advance  = !out_valid_ff || rsp_port.ready;
   assign step     = in_valid_ff && advance;
   assign req_port.ready = !in_valid_ff || advance;
   assign req_take = req_port.valid && req_port.ready;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? 1'b1 : (rsp_port.ready ? 1'b0 : out_valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_word_ff <= req_port.raw_word;
      end
   end

   bpp_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .raw_word (in_word_ff),
      .result   (dec_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step) begin
         out_ff <= dec_result;
      end
   end

   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.word_kind     = out_ff.word_kind;
   assign rsp_port.reg_addr      = out_ff.reg_addr;
   assign rsp_port.word_value    = out_ff.word_value;
   assign rsp_port.payload_last  = out_ff.payload_last;
   assign rsp_port.byte_swapped  = out_ff.byte_swapped;
   assign rsp_port.command_valid = out_ff.command_valid;
   assign rsp_port.gwe_cycle     = out_ff.gwe_cycle;
   assign rsp_port.gts_cycle     = out_ff.gts_cycle;
   assign rsp_port.lock_wait     = out_ff.lock_wait;
   assign rsp_port.match_wait    = out_ff.match_wait;
   assign rsp_port.done_cycle    = out_ff.done_cycle;

`ifndef NO_ASSERTIONS
   // a held input word is not overwritten while the decoder is stalled
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_word_ff))
      else $error("input register changed while stalled");

   // payload_last, command_valid and done_cycle stay clear on every other kind of result
   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.word_kind != KIND_PAYLOAD) |->
      !out_ff.payload_last && !out_ff.command_valid && (out_ff.done_cycle == 3'd0))
      else $error("payload fields set on a non-payload result");

   // a decoded word always lands in the result register
   a_step_out: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("decoded transaction lost");
`endif

endmodule

### tb/stream_decode_checker.sv
module stream_decode_checker (
   input  logic clock,
   input  logic reset,
   bpp_req_if   req_mon,
   bpp_rsp_if   rsp_mon,
   output int   mismatches,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import bpp_pkg::*;

   // parser state as the block should be holding it
   logic               in_sync;
   logic               swap_order;
   logic [COUNT_W-1:0] words_left;
   logic [ADDR_W-1:0]  cur_reg;

   // decoded words still waiting for their response transaction
   result_type decoded_q[$];
   int         results_seen = 0;
   int         fail_total   = 0;

   assign mismatches = fail_total;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] response %0d: %s is 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
      fail_total++;
   endtask

   // decode one stream word and advance the parser state
   function automatic result_type decode_word(input logic [31:0] raw);
      result_type r;
      logic [31:0] v;
      int          b;
      r = '0;
      if (!in_sync) begin
         if (raw == SYNC_NATIVE) begin
            in_sync    = 1'b1;
            swap_order = 1'b0;
            r.word_kind = KIND_SYNC;
         end else if (raw == SYNC_SWAPPED) begin
            in_sync    = 1'b1;
            swap_order = 1'b1;
            r.word_kind = KIND_SYNC;
         end else begin
            r.word_kind = KIND_HUNT;
         end
      end

      // byte order correction uses the mode after any latch on this word
      v = raw;
      if (swap_order)
         for (b = 0; b < 4; b++)
            v[8*b +: 8] = raw[8*(3-b) +: 8];

      if (in_sync && r.word_kind != KIND_SYNC) begin
         if (words_left != '0) begin
            // inside a packet everything is payload, whatever it looks like
            r.word_kind    = KIND_PAYLOAD;
            r.reg_addr     = cur_reg;
            r.payload_last = (words_left == COUNT_W'(1));
            words_left     = words_left - COUNT_W'(1);
            if (cur_reg == REG_COMMAND && v <= CMD_MAX)
               r.command_valid = 1'b1;
            if (cur_reg == REG_CONTROL) begin
               r.gwe_cycle  = v[2:0];
               r.gts_cycle  = v[5:3];
               r.lock_wait  = v[8:6];
               r.match_wait = v[11:9];
               r.done_cycle = v[14:12];
            end
         end else if (v == NOOP_WORD) begin
            r.word_kind = KIND_NOOP;
         end else if ((v & TYPE_MASK) == TYPE1_WRITE) begin
            r.word_kind = KIND_HEADER;
            words_left  = v[COUNT_W-1:0];
            cur_reg     = v[HDR_ADDR_LSB +: ADDR_W];
            r.reg_addr  = cur_reg;
         end else begin
            r.word_kind = KIND_UNKNOWN;
         end
      end
      r.word_value   = v;
      r.byte_swapped = swap_order;
      return r;
   endfunction

   // predict on each request, compare on each response
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         in_sync    = 1'b0;
         swap_order = 1'b0;
         words_left = '0;
         cur_reg    = '0;
         decoded_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            decoded_q.push_back(decode_word(req_mon.raw_word));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch("unrequested response, word_value", rsp_mon.word_value, '0);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_mon.word_kind !== want.word_kind)
                  report_mismatch("word_kind", 32'(rsp_mon.word_kind),
                                  32'(want.word_kind));
               if (rsp_mon.reg_addr !== want.reg_addr)
                  report_mismatch("reg_addr", 32'(rsp_mon.reg_addr), 32'(want.reg_addr));
               if (rsp_mon.word_value !== want.word_value)
                  report_mismatch("word_value", rsp_mon.word_value, want.word_value);
               if (rsp_mon.payload_last !== want.payload_last)
                  report_mismatch("payload_last", 32'(rsp_mon.payload_last),
                                  32'(want.payload_last));
               if (rsp_mon.byte_swapped !== want.byte_swapped)
                  report_mismatch("byte_swapped", 32'(rsp_mon.byte_swapped),
                                  32'(want.byte_swapped));
               if (rsp_mon.command_valid !== want.command_valid)
                  report_mismatch("command_valid", 32'(rsp_mon.command_valid),
                                  32'(want.command_valid));
               if (rsp_mon.gwe_cycle !== want.gwe_cycle)
                  report_mismatch("gwe_cycle", 32'(rsp_mon.gwe_cycle), 32'(want.gwe_cycle));
               if (rsp_mon.gts_cycle !== want.gts_cycle)
                  report_mismatch("gts_cycle", 32'(rsp_mon.gts_cycle), 32'(want.gts_cycle));
               if (rsp_mon.lock_wait !== want.lock_wait)
                  report_mismatch("lock_wait", 32'(rsp_mon.lock_wait), 32'(want.lock_wait));
               if (rsp_mon.match_wait !== want.match_wait)
                  report_mismatch("match_wait", 32'(rsp_mon.match_wait),
                                  32'(want.match_wait));
               if (rsp_mon.done_cycle !== want.done_cycle)
                  report_mismatch("done_cycle", 32'(rsp_mon.done_cycle),
                                  32'(want.done_cycle));
            end
            results_seen++;
         end
      end
      // published with a nonblocking assignment so the stimulus side reads it without a race
      outstanding <= decoded_q.size();
   end

endmodule

### tb/tb_bitstream_packet_parser.sv
module tb_bitstream_packet_parser;
   timeunit 1ns;
   timeprecision 1ps;
   import bpp_pkg::*;

   localparam int IDLE_LIMIT = 5000;   // cycles with no transaction on either channel
   localparam int HOLD_AFTER = 500;    // responses taken before the long receiver hold-off
   localparam int HOLD_LEN   = 300;

   logic clock;
   logic reset;

   bpp_req_if req_ch ();
   bpp_rsp_if rsp_ch ();

   int   mismatches;
   int   outstanding;
   logic swap_stream;
   int   words_sent    = 0;
   int   headers_sent  = 0;
   int   payload_total = 0;
   int   calm_left     = 0;
   int   idle_cycles   = 0;

   bitstream_packet_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   stream_decode_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // offer one raw word after a random gap, return once it is taken
   task automatic send_raw(input logic [31:0] raw);
      int gap;
      int r;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            calm_left = $urandom_range(30, 150);
            gap = 0;
         end else if (r < 60) gap = 0;
         else if (r < 90) gap = $urandom_range(1, 3);
         else if (r < 97) gap = $urandom_range(4, 10);
         else gap = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.raw_word <= raw;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   // words after sync are written in stream order, so flip them for a swapped stream
   task automatic send_value(input logic [31:0] v);
      send_raw(swap_stream ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v);
   endtask

   task automatic send_header(input logic [ADDR_W-1:0] addr, input logic [COUNT_W-1:0] run_len);
      headers_sent++;
      payload_total += run_len;
      send_value({4'h3, 10'($urandom), addr, 2'($urandom), run_len});
   endtask

   // header plus payload; command payloads lean toward the valid range edge
   task automatic send_packet(input logic [COUNT_W-1:0] run_len);
      logic [ADDR_W-1:0] addr;
      logic [31:0]       v;
      int                sel;
      sel  = $urandom_range(0, 2);
      addr = (sel == 0) ? REG_COMMAND : (sel == 1) ? REG_CONTROL : ADDR_W'($urandom);
      send_header(addr, run_len);
      for (int i = 0; i < run_len; i++) begin
         v = $urandom;
         if (addr == REG_COMMAND && $urandom_range(0, 3) != 0)
            v = $urandom_range(0, 25);
         send_value(v);
      end
   endtask

   // stop offering until every response is back
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // receiver: random stalls, calm stretches, and one long hold-off
   initial begin : rsp_pacer
      int stall_left;
      int calm;
      int taken;
      int r;
      bit held;
      stall_left = 0;
      calm       = 0;
      taken      = 0;
      held       = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            taken++;
         if (!held && taken >= HOLD_AFTER) begin
            held       = 1'b1;
            stall_left = HOLD_LEN;
         end else if (stall_left == 0 && calm == 0) begin
            r = $urandom_range(0, 99);
            if (r < 8) calm = $urandom_range(30, 120);
            else if (r < 30) stall_left = $urandom_range(1, 3);
            else if (r < 34) stall_left = $urandom_range(10, 40);
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (calm > 0)
               calm--;
         end
      end
   end

   // watchdog on transaction activity
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] v;
      int          r;
      int          stop_at;
      bit          mid_drained;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.raw_word <= '0;
      swap_stream = 1'($urandom_range(0, 1));
      mid_drained = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // hunting: junk, a noop and a header are all ignored before sync
      send_raw(32'h0000_0000);
      send_raw(32'hFFFF_FFFF);
      send_raw(NOOP_WORD);
      send_raw(32'h3000_8002);
      // sync in the chosen byte order
      send_value(SYNC_NATIVE);

      send_value(NOOP_WORD);
      // command register: both sides of the valid limit
      send_header(REG_COMMAND, 11'd3);
      send_value(32'd0);
      send_value(32'd19);
      send_value(32'd20);
      // control register: all fields max, then all zero
      send_header(REG_CONTROL, 11'd2);
      send_value(32'hFFFF_FFFF);
      send_value(32'h0000_0000);
      // empty packet, repeated sync and a type 2 word
      send_header(5'd31, 11'd0);
      send_value(SYNC_NATIVE);
      send_value({4'h5, 28'($urandom)});
      // payload that looks like noop, header and sync
      send_header(5'd0, 11'd4);
      send_value(NOOP_WORD);
      send_value(32'h3000_07FF);
      send_value(SYNC_NATIVE);
      send_value(32'hFFFF_FFFF);
      send_header(REG_COMMAND, 11'd1);
      send_value(32'hFFFF_FFFF);
      drain();

      // one long packet with only bit 9 of the count set, then mostly short packets and noise
      send_packet(11'h200);
      stop_at = words_sent + 750;
      while (words_sent < stop_at) begin
         if (!mid_drained && words_sent > stop_at - 375) begin
            mid_drained = 1'b1;
            drain();
         end
         r = $urandom_range(0, 99);
         if (r < 70) begin
            r = $urandom_range(0, 99);
            if (r < 15) send_packet(11'd0);
            else if (r < 85) send_packet(COUNT_W'($urandom_range(1, 6)));
            else send_packet(COUNT_W'($urandom_range(7, 40)));
         end else if (r < 76) begin
            send_value(NOOP_WORD);
         end else if (r < 80) begin
            send_value(NOOP_WORD ^ (32'd1 << $urandom_range(0, 27)));
         end else if (r < 84) begin
            send_value(SYNC_NATIVE);
         end else if (r < 90) begin
            send_value({4'h5, 28'($urandom)});
         end else begin
            // random word that is not a type 1 header
            v = $urandom;
            if (v[31:28] == 4'h3)
               v[31:28] = 4'h7;
            send_value(v);
         end
      end
      drain();
      repeat (8) @(posedge clock);

      $display("covered %0d stream words, %s byte order, %0d type 1 headers, %0d payload words",
               words_sent, swap_stream ? "swapped" : "native", headers_sent, payload_total);
      $display("with random stalls on both sides and one %0d cycle receiver hold-off", HOLD_LEN);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### filelist.f
hdl/bpp_pkg.sv
hdl/bpp_if.sv
hdl/bpp_decode.sv
hdl/bitstream_packet_parser.sv
tb/stream_decode_checker.sv
tb/tb_bitstream_packet_parser.sv
